/* sv/script_tokenizer_defines.svh */
// Assertion macros shared by the tokenizer checkers.
// Expects clk_i and rst_ni to be visible where a macro is used.
`ifndef SCRIPT_TOKENIZER_DEFINES_SVH
`define SCRIPT_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge
`define STK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication
`define STK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

/* sv/stk_pkg.sv */
// Shared types and constants of the script tokenizer.
// No dependencies; used by every other source file but the defines header.
`timescale 1ns / 1ps

package stk_pkg;

  // Request and result payloads
  typedef struct packed {
    logic       req_type;
    logic [7:0] ch;
  } req_t;

  typedef struct packed {
    logic [2:0]  token_class;
    logic [7:0]  tok_char;
    logic        char_valid;
    logic        last;
    logic [15:0] row_num;
    logic [15:0] col_num;
  } res_t;

  // Token classes
  localparam logic [2:0] TC_IDENT   = 3'd0;
  localparam logic [2:0] TC_NUMBER  = 3'd1;
  localparam logic [2:0] TC_BRACKET = 3'd2;
  localparam logic [2:0] TC_ARROW   = 3'd3;
  localparam logic [2:0] TC_OPER    = 3'd4;
  localparam logic [2:0] TC_DELIM   = 3'd5;
  localparam logic [2:0] TC_STRING  = 3'd6;
  localparam logic [2:0] TC_ERROR   = 3'd7;

  // Characters the lexer cares about
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_LO  = 8'h41;
  localparam logic [7:0] CH_UP_HI  = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_LO  = 8'h61;
  localparam logic [7:0] CH_LO_HI  = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // Character classes worked out by the front end
  typedef enum logic [3:0] {
    CC_SPACE,
    CC_NEWLINE,
    CC_IGNORE,
    CC_HASH,
    CC_ALPHA,
    CC_DIGIT,
    CC_BRACKET,
    CC_OPSINGLE,
    CC_OPHOLD,
    CC_DELIM,
    CC_QUOTE,
    CC_OTHER
  } cc_e;

  // Classified request passed from front to back
  typedef struct packed {
    logic       eos;
    logic [7:0] ch;
    cc_e        cls;
  } lex_item_t;

  // Queue between front and back (power of two)
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // Result buffer (power of two, at least four)
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  // Largest value the result position fields can show
  localparam logic [15:0] POS_OUT_MAX = 16'hFFFF;

endpackage

/* sv/stk_front.sv */
// Front end of the tokenizer: classifies each incoming request.
// Depends on stk_pkg.
`timescale 1ns / 1ps

module stk_front (
  input  stk_pkg::req_t      req_i,
  output stk_pkg::lex_item_t item_o
);

  stk_pkg::cc_e cls;

  // Byte class lookup
  always_comb begin
    case (req_i.ch) inside
      stk_pkg::CH_SPACE:                          cls = stk_pkg::CC_SPACE;
      stk_pkg::CH_LF, stk_pkg::CH_CR:             cls = stk_pkg::CC_NEWLINE;
      stk_pkg::CH_TAB, stk_pkg::CH_VT, stk_pkg::CH_FF:
                                                  cls = stk_pkg::CC_IGNORE;
      stk_pkg::CH_HASH:                           cls = stk_pkg::CC_HASH;
      [stk_pkg::CH_LO_LO:stk_pkg::CH_LO_HI],
      [stk_pkg::CH_UP_LO:stk_pkg::CH_UP_HI],
      stk_pkg::CH_UNDER:                          cls = stk_pkg::CC_ALPHA;
      [stk_pkg::CH_DIG_LO:stk_pkg::CH_DIG_HI]:   cls = stk_pkg::CC_DIGIT;
      stk_pkg::CH_LPAREN, stk_pkg::CH_RPAREN, stk_pkg::CH_LBRACE,
      stk_pkg::CH_RBRACE, stk_pkg::CH_LBRACK, stk_pkg::CH_RBRACK:
                                                  cls = stk_pkg::CC_BRACKET;
      stk_pkg::CH_PLUS, stk_pkg::CH_STAR, stk_pkg::CH_SLASH:
                                                  cls = stk_pkg::CC_OPSINGLE;
      stk_pkg::CH_MINUS, stk_pkg::CH_LT, stk_pkg::CH_GT, stk_pkg::CH_EQ,
      stk_pkg::CH_BANG, stk_pkg::CH_AMP, stk_pkg::CH_PIPE, stk_pkg::CH_TILDE:
                                                  cls = stk_pkg::CC_OPHOLD;
      stk_pkg::CH_SEMI, stk_pkg::CH_COMMA:        cls = stk_pkg::CC_DELIM;
      stk_pkg::CH_QUOTE:                          cls = stk_pkg::CC_QUOTE;
      default:                                    cls = stk_pkg::CC_OTHER;
    endcase
  end

  // A zero byte ends the script just like an explicit end request
  assign item_o.eos = req_i.req_type | (req_i.ch == stk_pkg::CH_NUL);
  assign item_o.ch  = req_i.ch;
  assign item_o.cls = cls;

endmodule

/* sv/stk_queue.sv */
// Short queue of classified requests between front and back end.
// Depends on stk_pkg.
`timescale 1ns / 1ps

module stk_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  stk_pkg::lex_item_t  wr_item_i,
  output logic                full_o,
  input  logic                rd_en_i,
  output logic                rd_valid_o,
  output stk_pkg::lex_item_t  rd_item_o
);

  stk_pkg::lex_item_t     mem_q [stk_pkg::QDEPTH];
  logic [stk_pkg::QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [stk_pkg::QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [stk_pkg::QAW:0]   cnt_q, cnt_d;
  logic                    do_wr, do_rd;

  assign full_o     = (cnt_q == (stk_pkg::QAW + 1)'(stk_pkg::QDEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];

  assign do_wr = wr_en_i & ~full_o;
  assign do_rd = rd_en_i & rd_valid_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + stk_pkg::QAW'(1) : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + stk_pkg::QAW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (stk_pkg::QAW + 1)'(do_wr) - (stk_pkg::QAW + 1)'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

/* sv/stk_back.sv */
// Back end of the tokenizer: lexer state machine, position counters and
// result buffer. Depends on stk_pkg.
`timescale 1ns / 1ps

module stk_back #(
  parameter int POS_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  stk_pkg::lex_item_t  in_item_i,
  output logic                in_take_o,
  output logic                empty_o,
  input  logic                pop_i,
  output stk_pkg::res_t       res_o
);

  localparam int CW = (POS_BITS > 16) ? POS_BITS : 16;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_OPER    = 3'd3;
  localparam logic [2:0] MODE_STRING  = 3'd4;
  localparam logic [2:0] MODE_COMMENT = 3'd5;
  localparam logic [2:0] MODE_HALT    = 3'd6;

  // Saturating position step
  function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] x);
    return (x == {POS_BITS{1'b1}}) ? x : x + POS_BITS'(1);
  endfunction

  // Clamp a position to the 16-bit result field
  function automatic logic [15:0] pos_out(input logic [POS_BITS-1:0] x);
    logic [CW-1:0] w;
    w = CW'(x);
    return (w > CW'(stk_pkg::POS_OUT_MAX)) ? stk_pkg::POS_OUT_MAX : w[15:0];
  endfunction

  function automatic stk_pkg::res_t mk_res(input logic [2:0] cls, input logic [7:0] c,
                                            input logic v, input logic l,
                                            input logic [POS_BITS-1:0] r,
                                            input logic [POS_BITS-1:0] col);
    stk_pkg::res_t o;
    o.token_class = cls;
    o.tok_char    = c;
    o.char_valid  = v;
    o.last        = l;
    o.row_num     = pos_out(r);
    o.col_num     = pos_out(col);
    return o;
  endfunction

  // Two-character operator forms other than the arrow
  function automatic logic is_pair(input logic [7:0] h, input logic [7:0] c);
    logic eq_form, dbl_form;
    eq_form  = (c == stk_pkg::CH_EQ) &&
               !(h inside {stk_pkg::CH_PLUS, stk_pkg::CH_MINUS,
                           stk_pkg::CH_STAR, stk_pkg::CH_SLASH});
    dbl_form = (h == c) && (c inside {stk_pkg::CH_GT, stk_pkg::CH_LT,
                                      stk_pkg::CH_AMP, stk_pkg::CH_PIPE});
    return eq_form | dbl_form;
  endfunction

  logic [2:0]          mode_q, mode_d;
  logic [7:0]          held_q, held_d;
  logic                hv_q, hv_d;
  logic [POS_BITS-1:0] row_q, row_d;
  logic [POS_BITS-1:0] col_q, col_d;
  logic [POS_BITS-1:0] col_up;

  stk_pkg::res_t       buf_q [stk_pkg::OUT_DEPTH];
  logic [stk_pkg::OUT_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [stk_pkg::OUT_AW:0]   cnt_q, cnt_d;

  logic          take, do_pop;
  logic          a_v, b_v, bg_run;
  stk_pkg::res_t a_item, b_item, w0_item;
  logic [1:0]    n_wr;
  logic [7:0]    c;

  // Outcome of starting a fresh token with the current byte
  logic          bg_emit;
  stk_pkg::res_t bg_item;
  logic [2:0]    bg_mode;
  logic [7:0]    bg_held;
  logic          bg_hv;
  logic [POS_BITS-1:0] bg_row, bg_col;

  assign c      = in_item_i.ch;
  assign col_up = pos_inc(col_q);

  // Take a request only when two result slots are free
  assign take      = in_valid_i & (cnt_q <= (stk_pkg::OUT_AW + 1)'(stk_pkg::OUT_DEPTH - 2));
  assign in_take_o = take;
  assign empty_o   = (cnt_q == '0);
  assign do_pop    = pop_i & ~empty_o;
  assign res_o     = buf_q[rd_q];

  // Token start from idle
  always_comb begin
    bg_emit = 1'b0;
    bg_item = mk_res(stk_pkg::TC_ERROR, c, 1'b0, 1'b1, row_q, col_q);
    bg_mode = MODE_IDLE;
    bg_held = held_q;
    bg_hv   = 1'b0;
    bg_row  = row_q;
    bg_col  = col_q;
    case (in_item_i.cls)
      stk_pkg::CC_SPACE: bg_col = col_up;
      stk_pkg::CC_NEWLINE: begin
        bg_row = pos_inc(row_q);
        bg_col = POS_BITS'(1);
      end
      stk_pkg::CC_IGNORE: ;
      stk_pkg::CC_HASH: begin
        bg_col  = col_up;
        bg_mode = MODE_COMMENT;
      end
      stk_pkg::CC_ALPHA: begin
        bg_col  = col_up;
        bg_held = c;
        bg_hv   = 1'b1;
        bg_mode = MODE_IDENT;
      end
      stk_pkg::CC_DIGIT: begin
        bg_col  = col_up;
        bg_held = c;
        bg_hv   = 1'b1;
        bg_mode = MODE_NUMBER;
      end
      stk_pkg::CC_BRACKET: begin
        bg_col  = col_up;
        bg_emit = 1'b1;
        bg_item = mk_res(stk_pkg::TC_BRACKET, c, 1'b1, 1'b1, row_q, col_up);
      end
      stk_pkg::CC_OPSINGLE: begin
        bg_col  = col_up;
        bg_emit = 1'b1;
        bg_item = mk_res(stk_pkg::TC_OPER, c, 1'b1, 1'b1, row_q, col_up);
      end
      stk_pkg::CC_OPHOLD: begin
        bg_col  = col_up;
        bg_held = c;
        bg_hv   = 1'b1;
        bg_mode = MODE_OPER;
      end
      stk_pkg::CC_DELIM: begin
        bg_col  = col_up;
        bg_emit = 1'b1;
        bg_item = mk_res(stk_pkg::TC_DELIM, c, 1'b1, 1'b1, row_q, col_up);
      end
      stk_pkg::CC_QUOTE: bg_mode = MODE_STRING;
      default: begin
        // unknown byte: error item, then halt until end of script
        bg_emit = 1'b1;
        bg_mode = MODE_HALT;
      end
    endcase
  end

  // Lexer step: up to two result items per request
  always_comb begin
    mode_d = mode_q;
    held_d = held_q;
    hv_d   = hv_q;
    row_d  = row_q;
    col_d  = col_q;
    a_v    = 1'b0;
    b_v    = 1'b0;
    a_item = mk_res(stk_pkg::TC_IDENT, held_q, 1'b1, 1'b1, row_q, col_q);
    b_item = a_item;
    bg_run = 1'b0;
    if (take) begin
      if (in_item_i.eos) begin
        // flush whatever is held, then back to the reset state
        case (mode_q)
          MODE_IDENT: a_v = 1'b1;
          MODE_NUMBER: begin
            a_v = 1'b1;
            a_item.token_class = stk_pkg::TC_NUMBER;
          end
          MODE_OPER: begin
            a_v = 1'b1;
            a_item.token_class = stk_pkg::TC_OPER;
          end
          MODE_STRING, MODE_COMMENT: begin
            a_v    = 1'b1;
            a_item = mk_res(stk_pkg::TC_ERROR, stk_pkg::CH_NUL, 1'b0, 1'b1, row_q, col_q);
          end
          default: ;
        endcase
        mode_d = MODE_IDLE;
        held_d = '0;
        hv_d   = 1'b0;
        row_d  = POS_BITS'(1);
        col_d  = POS_BITS'(1);
      end else begin
        case (mode_q)
          MODE_IDENT, MODE_NUMBER: begin
            a_v = 1'b1;
            if (mode_q == MODE_NUMBER) begin
              a_item.token_class = stk_pkg::TC_NUMBER;
            end
            if ((in_item_i.cls == stk_pkg::CC_DIGIT) ||
                ((mode_q == MODE_IDENT) && (in_item_i.cls == stk_pkg::CC_ALPHA))) begin
              a_item.last = 1'b0;
              held_d      = c;
              col_d       = col_up;
            end else begin
              bg_run = 1'b1;
            end
          end
          MODE_OPER: begin
            a_v = 1'b1;
            a_item.token_class = stk_pkg::TC_OPER;
            if ((held_q == stk_pkg::CH_MINUS) && (c == stk_pkg::CH_GT)) begin
              a_item = mk_res(stk_pkg::TC_ARROW, held_q, 1'b1, 1'b0, row_q, col_q);
              b_v    = 1'b1;
              b_item = mk_res(stk_pkg::TC_ARROW, c, 1'b1, 1'b1, row_q, col_up);
              mode_d = MODE_IDLE;
              hv_d   = 1'b0;
              col_d  = col_up;
            end else if (is_pair(held_q, c)) begin
              a_item.last = 1'b0;
              b_v    = 1'b1;
              b_item = mk_res(stk_pkg::TC_OPER, c, 1'b1, 1'b1, row_q, col_up);
              mode_d = MODE_IDLE;
              hv_d   = 1'b0;
              col_d  = col_up;
            end else begin
              bg_run = 1'b1;
            end
          end
          MODE_STRING: begin
            // one character is held back so the closing quote can mark last
            if (in_item_i.cls == stk_pkg::CC_QUOTE) begin
              a_v    = 1'b1;
              a_item = mk_res(stk_pkg::TC_STRING, hv_q ? held_q : stk_pkg::CH_NUL,
                              hv_q, 1'b1, row_q, col_q);
              mode_d = MODE_IDLE;
              hv_d   = 1'b0;
            end else begin
              a_v    = hv_q;
              a_item = mk_res(stk_pkg::TC_STRING, held_q, 1'b1, 1'b0, row_q, col_q);
              held_d = c;
              hv_d   = 1'b1;
              col_d  = col_up;
            end
          end
          MODE_COMMENT: begin
            col_d = col_up;
            if (in_item_i.cls == stk_pkg::CC_HASH) begin
              mode_d = MODE_IDLE;
            end
          end
          MODE_IDLE: bg_run = 1'b1;
          default: ;
        endcase
        if (bg_run) begin
          mode_d = bg_mode;
          held_d = bg_held;
          hv_d   = bg_hv;
          row_d  = bg_row;
          col_d  = bg_col;
          b_v    = bg_emit;
          b_item = bg_item;
        end
      end
    end
  end

  // Compact the two slots into consecutive buffer writes
  assign w0_item = a_v ? a_item : b_item;
  assign n_wr    = 2'(a_v) + 2'(b_v);

  always_comb begin
    wr_d  = wr_q + stk_pkg::OUT_AW'(n_wr);
    rd_d  = do_pop ? rd_q + stk_pkg::OUT_AW'(1) : rd_q;
    cnt_d = cnt_q + (stk_pkg::OUT_AW + 1)'(n_wr) - (stk_pkg::OUT_AW + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      held_q <= '0;
      hv_q   <= 1'b0;
      row_q  <= POS_BITS'(1);
      col_q  <= POS_BITS'(1);
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
    end else begin
      mode_q <= mode_d;
      held_q <= held_d;
      hv_q   <= hv_d;
      row_q  <= row_d;
      col_q  <= col_d;
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      cnt_q  <= cnt_d;
    end
  end

  // Result buffer storage
  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) begin
      buf_q[wr_q] <= w0_item;
    end
    if (n_wr == 2'd2) begin
      buf_q[wr_q + stk_pkg::OUT_AW'(1)] <= b_item;
    end
  end

endmodule

/* sv/script_tokenizer.sv */
// Top level of the script tokenizer: front classifier, request queue and
// lexer back end. Depends on stk_pkg, stk_front, stk_queue and stk_back.
//
// Usage:
//   Requests go in on req_i with push; one is taken at each rising edge with
//   push high and full low. req_type 1 (or a zero byte) ends the script.
//   Results come out on res_o while empty is low, one token character per
//   item, and leave at each rising edge with pop high and empty low.
//   A request is written into the queue at the edge that takes it; the lexer
//   step then writes its results into the result buffer for popping.
//   Throughput: one byte per cycle unless stalled. A byte yields zero, one
//   or two results; the result port moves one per cycle, so runs of two-result
//   bytes drain at one result per cycle and back up into the request queue.
//   The lexer steps only when two of the four result buffer slots are free.
//   When the receiver stalls the buffer fills, the lexer stops, the
//   two-entry request queue fills and full rises; nothing is lost.
//   Reset clears the queue and buffer and puts the lexer in idle with row
//   and column at 1; a request can be pushed as soon as reset is released.
`timescale 1ns / 1ps

module script_tokenizer #(
  parameter int POS_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  stk_pkg::req_t  req_i,
  output logic           empty,
  input  logic           pop,
  output stk_pkg::res_t  res_o
);

  stk_pkg::lex_item_t front_item, head_item;
  logic               head_valid, head_take;

  stk_front u_front (
    .req_i  (req_i),
    .item_o (front_item)
  );

  stk_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (push),
    .wr_item_i  (front_item),
    .full_o     (full),
    .rd_en_i    (head_take),
    .rd_valid_o (head_valid),
    .rd_item_o  (head_item)
  );

  stk_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (head_valid),
    .in_item_i  (head_item),
    .in_take_o  (head_take),
    .empty_o    (empty),
    .pop_i      (pop),
    .res_o      (res_o)
  );

endmodule

/* sv/stk_checker.sv */
// Port-level checks of the script tokenizer, bound to the top level.
// Depends on stk_pkg and script_tokenizer_defines.svh.
`timescale 1ns / 1ps
`include "script_tokenizer_defines.svh"

module stk_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          empty,
  input logic          pop,
  input stk_pkg::res_t res_o
);

  // A waiting result stays put until it is taken
  `STK_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(res_o))

  // Error items carry no character and close their token
  `STK_ASSERT_NOW(a_err_shape, !empty && (res_o.token_class == stk_pkg::TC_ERROR), !res_o.char_valid && res_o.last)

  // An item without a character is always the end of its token
  `STK_ASSERT_NOW(a_blank_last, !empty && !res_o.char_valid, res_o.last)

  // Positions start at one
  `STK_ASSERT_NOW(a_pos_nonzero, !empty, (res_o.row_num != 16'd0) && (res_o.col_num != 16'd0))

endmodule

bind script_tokenizer stk_checker u_stk_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .empty  (empty),
  .pop    (pop),
  .res_o  (res_o)
);

/* verif/tb.sv */
// Self-checking testbench for script_tokenizer: a directed table and four
// flow-control phases of random scripts. Depends on stk_pkg.
`timescale 1ns / 1ps

module tb;

  // Lexer state as tracked by the predictor
  typedef enum logic [2:0] {
    LX_IDLE, LX_IDENT, LX_NUMBER, LX_OPER, LX_STRING, LX_COMMENT, LX_HALT
  } lex_state_e;

  // Directed row: typed marks a row whose single result is written out by hand
  typedef struct packed {
    logic          typed;
    stk_pkg::req_t req;
    stk_pkg::res_t want;
  } dir_row_t;

  localparam stk_pkg::res_t NO_RES = '0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  stk_pkg::req_t req_i = '0;
  stk_pkg::res_t res_o;

  // Predictor state
  lex_state_e  lx_state;
  logic [7:0]  lx_held;
  logic        lx_held_ok;
  logic [15:0] lx_row, lx_col;

  stk_pkg::res_t step_res[$];   // results of the request being predicted
  stk_pkg::res_t tok_due[$];    // token items still owed by the block

  int mismatches = 0;
  int res_seen = 0;
  int fed = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  int send_idle[4]  = '{0, 77, 0, 21};
  int recv_stall[4] = '{0, 0, 77, 21};

  // Character pools for the random scripts
  string id_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string id_body = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string digits  = "0123456789";
  string punct   = "(){}[];,";
  string ops     = "+-*/<>=!&|~";
  string op_tail = "=<>&|";
  logic [7:0] ws_set[6] = '{stk_pkg::CH_SPACE, stk_pkg::CH_TAB, stk_pkg::CH_LF,
                            stk_pkg::CH_CR, stk_pkg::CH_VT, stk_pkg::CH_FF};

  // Directed table: reset-state rows typed, the rest predicted
  dir_row_t dir_tab[25] = '{
    {1'b1, 1'b0, stk_pkg::CH_LPAREN,
     stk_pkg::TC_BRACKET, stk_pkg::CH_LPAREN, 1'b1, 1'b1, 16'd1, 16'd2},
    {1'b1, 1'b0, stk_pkg::CH_SEMI,
     stk_pkg::TC_DELIM, stk_pkg::CH_SEMI, 1'b1, 1'b1, 16'd1, 16'd3},
    {1'b1, 1'b0, 8'hFF,
     stk_pkg::TC_ERROR, 8'hFF, 1'b0, 1'b1, 16'd1, 16'd3},
    {1'b0, 1'b0, stk_pkg::CH_LO_LO,  NO_RES},   // halted: dropped
    {1'b0, 1'b1, 8'hFF,              NO_RES},   // end of script restarts
    {1'b0, 1'b0, stk_pkg::CH_UNDER,  NO_RES},
    {1'b0, 1'b0, stk_pkg::CH_LO_LO,  NO_RES},
    {1'b0, 1'b0, stk_pkg::CH_DIG_HI, NO_RES},
    {1'b0, 1'b0, stk_pkg::CH_SPACE,  NO_RES},
    {1'b0, 1'b0, stk_pkg::CH_MINUS,  NO_RES},
    {1'b0, 1'b0, stk_pkg::CH_GT,     NO_RES},   // arrow
    {1'b0, 1'b0, stk_pkg::CH_QUOTE,  NO_RES},
    {1'b0, 1'b0, stk_pkg::CH_QUOTE,  NO_RES},   // empty string
    {1'b0, 1'b0, stk_pkg::CH_LF,     NO_RES},
    {1'b0, 1'b0, stk_pkg::CH_DIG_LO, NO_RES},
    {1'b0, 1'b0, stk_pkg::CH_LT,     NO_RES},
    {1'b0, 1'b0, stk_pkg::CH_LT,     NO_RES},   // shift pair
    {1'b0, 1'b0, stk_pkg::CH_UP_HI,  NO_RES},
    {1'b0, 1'b0, 8'h01,              NO_RES},   // held ident, then unknown byte
    {1'b0, 1'b1, stk_pkg::CH_NUL,    NO_RES},
    {1'b0, 1'b0, stk_pkg::CH_QUOTE,  NO_RES},
    {1'b0, 1'b0, stk_pkg::CH_TAB,    NO_RES},
    {1'b0, 1'b0, stk_pkg::CH_NUL,    NO_RES},   // zero byte inside a string
    {1'b0, 1'b0, stk_pkg::CH_HASH,   NO_RES},
    {1'b0, 1'b1, stk_pkg::CH_NUL,    NO_RES}    // end inside a comment
  };

  script_tokenizer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .req_i  (req_i),
    .empty  (empty),
    .pop    (pop),
    .res_o  (res_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= stk_pkg::CH_LO_LO && c <= stk_pkg::CH_LO_HI) ||
           (c >= stk_pkg::CH_UP_LO && c <= stk_pkg::CH_UP_HI);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= stk_pkg::CH_DIG_LO && c <= stk_pkg::CH_DIG_HI;
  endfunction

  function automatic void lex_clear();
    lx_state   = LX_IDLE;
    lx_held    = '0;
    lx_held_ok = 1'b0;
    lx_row     = 16'd1;
    lx_col     = 16'd1;
  endfunction

  function automatic void col_step();
    if (lx_col != stk_pkg::POS_OUT_MAX) lx_col++;
  endfunction

  function automatic void put_tok(logic [2:0] cls, logic [7:0] c, logic ok, logic fin);
    stk_pkg::res_t r;
    r.token_class = cls;
    r.tok_char    = c;
    r.char_valid  = ok;
    r.last        = fin;
    r.row_num     = lx_row;
    r.col_num     = lx_col;
    step_res.push_back(r);
  endfunction

  // First byte of a token, from idle
  function automatic void lex_begin(logic [7:0] c);
    lx_state   = LX_IDLE;
    lx_held_ok = 1'b0;
    if (c == stk_pkg::CH_SPACE) begin
      col_step();
    end else if (c == stk_pkg::CH_LF || c == stk_pkg::CH_CR) begin
      if (lx_row != stk_pkg::POS_OUT_MAX) lx_row++;
      lx_col = 16'd1;
    end else if (c == stk_pkg::CH_TAB || c == stk_pkg::CH_VT || c == stk_pkg::CH_FF) begin
      // no effect on position
    end else if (c == stk_pkg::CH_HASH) begin
      col_step();
      lx_state = LX_COMMENT;
    end else if (is_alpha(c) || c == stk_pkg::CH_UNDER || is_digit(c)) begin
      col_step();
      lx_held    = c;
      lx_held_ok = 1'b1;
      lx_state   = is_digit(c) ? LX_NUMBER : LX_IDENT;
    end else if (c == stk_pkg::CH_LPAREN || c == stk_pkg::CH_RPAREN ||
                 c == stk_pkg::CH_LBRACE || c == stk_pkg::CH_RBRACE ||
                 c == stk_pkg::CH_LBRACK || c == stk_pkg::CH_RBRACK) begin
      col_step();
      put_tok(stk_pkg::TC_BRACKET, c, 1'b1, 1'b1);
    end else if (c == stk_pkg::CH_PLUS || c == stk_pkg::CH_STAR ||
                 c == stk_pkg::CH_SLASH) begin
      col_step();
      put_tok(stk_pkg::TC_OPER, c, 1'b1, 1'b1);
    end else if (c == stk_pkg::CH_MINUS || c == stk_pkg::CH_LT || c == stk_pkg::CH_GT ||
                 c == stk_pkg::CH_EQ || c == stk_pkg::CH_BANG || c == stk_pkg::CH_AMP ||
                 c == stk_pkg::CH_PIPE || c == stk_pkg::CH_TILDE) begin
      col_step();
      lx_held    = c;
      lx_held_ok = 1'b1;
      lx_state   = LX_OPER;
    end else if (c == stk_pkg::CH_SEMI || c == stk_pkg::CH_COMMA) begin
      col_step();
      put_tok(stk_pkg::TC_DELIM, c, 1'b1, 1'b1);
    end else if (c == stk_pkg::CH_QUOTE) begin
      lx_state = LX_STRING;
    end else begin
      put_tok(stk_pkg::TC_ERROR, c, 1'b0, 1'b1);
      lx_state = LX_HALT;
    end
  endfunction

  // One request through the lexer; results land in step_res
  function automatic void lex_step(stk_pkg::req_t r);
    logic [7:0] c, h;
    logic [2:0] cls;
    bit more, pair;
    c = r.ch;
    h = lx_held;
    // end of script: flush the held token, then back to reset values
    if (r.req_type || c == stk_pkg::CH_NUL) begin
      case (lx_state)
        LX_IDENT:              put_tok(stk_pkg::TC_IDENT, h, 1'b1, 1'b1);
        LX_NUMBER:             put_tok(stk_pkg::TC_NUMBER, h, 1'b1, 1'b1);
        LX_OPER:               put_tok(stk_pkg::TC_OPER, h, 1'b1, 1'b1);
        LX_STRING, LX_COMMENT: put_tok(stk_pkg::TC_ERROR, stk_pkg::CH_NUL, 1'b0, 1'b1);
        default: ;
      endcase
      lex_clear();
      return;
    end
    case (lx_state)
      LX_IDENT, LX_NUMBER: begin
        cls  = (lx_state == LX_IDENT) ? stk_pkg::TC_IDENT : stk_pkg::TC_NUMBER;
        more = (lx_state == LX_IDENT) ?
               (is_alpha(c) || is_digit(c) || c == stk_pkg::CH_UNDER) : is_digit(c);
        if (more) begin
          put_tok(cls, h, 1'b1, 1'b0);
          lx_held = c;
          col_step();
        end else begin
          put_tok(cls, h, 1'b1, 1'b1);
          lex_begin(c);
        end
      end
      LX_OPER: begin
        pair = (c == stk_pkg::CH_EQ && h != stk_pkg::CH_PLUS && h != stk_pkg::CH_MINUS &&
                h != stk_pkg::CH_STAR && h != stk_pkg::CH_SLASH) ||
               (h == c && (c == stk_pkg::CH_GT || c == stk_pkg::CH_LT ||
                           c == stk_pkg::CH_AMP || c == stk_pkg::CH_PIPE));
        if ((h == stk_pkg::CH_MINUS && c == stk_pkg::CH_GT) || pair) begin
          cls = (h == stk_pkg::CH_MINUS && c == stk_pkg::CH_GT) ?
                stk_pkg::TC_ARROW : stk_pkg::TC_OPER;
          put_tok(cls, h, 1'b1, 1'b0);
          col_step();
          put_tok(cls, c, 1'b1, 1'b1);
          lx_state   = LX_IDLE;
          lx_held_ok = 1'b0;
        end else begin
          put_tok(stk_pkg::TC_OPER, h, 1'b1, 1'b1);
          lex_begin(c);
        end
      end
      LX_STRING: begin
        if (c == stk_pkg::CH_QUOTE) begin
          if (lx_held_ok) put_tok(stk_pkg::TC_STRING, h, 1'b1, 1'b1);
          else put_tok(stk_pkg::TC_STRING, stk_pkg::CH_NUL, 1'b0, 1'b1);
          lx_state   = LX_IDLE;
          lx_held_ok = 1'b0;
        end else begin
          if (lx_held_ok) put_tok(stk_pkg::TC_STRING, h, 1'b1, 1'b0);
          lx_held    = c;
          lx_held_ok = 1'b1;
          col_step();
        end
      end
      LX_COMMENT: begin
        col_step();
        if (c == stk_pkg::CH_HASH) lx_state = LX_IDLE;
      end
      LX_IDLE: lex_begin(c);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Drive one request, wait for it to be taken, then record what it owes
  task automatic send_req(input logic rt, input logic [7:0] c,
                          input logic typed = 1'b0, input stk_pkg::res_t want = '0);
    stk_pkg::req_t r;
    r.req_type = rt;
    r.ch       = c;
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push  <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (full);
    fed++;
    step_res.delete();
    lex_step(r);
    if (typed) tok_due.push_back(want);
    else foreach (step_res[k]) tok_due.push_back(step_res[k]);
  endtask

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] any_but(logic [7:0] x);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == x);
    return c;
  endfunction

  // One script of random tokens; a broken one carries noise or an unclosed
  // string or comment
  task automatic feed_script(input bit broken);
    int ntok, bad_at;
    bit cut;
    ntok   = $urandom_range(1, 8);
    bad_at = broken ? $urandom_range(0, ntok - 1) : -1;
    cut    = 1'b0;
    for (int t = 0; t < ntok && !cut; t++) begin
      if (t == bad_at) begin
        case ($urandom_range(0, 2))
          0: send_req(1'b0, 8'($urandom_range(0, 255)));
          1: begin
            send_req(1'b0, stk_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 3)) send_req(1'b0, pick(id_body));
            cut = 1'b1;
          end
          default: begin
            send_req(1'b0, stk_pkg::CH_HASH);
            repeat ($urandom_range(0, 3)) send_req(1'b0, pick(id_body));
            cut = 1'b1;
          end
        endcase
      end
      if (!cut) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            send_req(1'b0, pick(id_head));
            repeat ($urandom_range(0, 5)) send_req(1'b0, pick(id_body));
          end
          2: repeat ($urandom_range(1, 4)) send_req(1'b0, pick(digits));
          3: send_req(1'b0, pick(punct));
          4: begin
            send_req(1'b0, pick(ops));
            if ($urandom_range(0, 1)) send_req(1'b0, pick(op_tail));
          end
          5: begin
            send_req(1'b0, stk_pkg::CH_MINUS);
            send_req(1'b0, stk_pkg::CH_GT);
          end
          6: begin
            send_req(1'b0, stk_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 4)) send_req(1'b0, any_but(stk_pkg::CH_QUOTE));
            send_req(1'b0, stk_pkg::CH_QUOTE);
          end
          7: begin
            send_req(1'b0, stk_pkg::CH_HASH);
            repeat ($urandom_range(0, 3)) send_req(1'b0, any_but(stk_pkg::CH_HASH));
            send_req(1'b0, stk_pkg::CH_HASH);
          end
          default: send_req(1'b0, ws_set[$urandom_range(0, 5)]);
        endcase
        if ($urandom_range(0, 1)) send_req(1'b0, stk_pkg::CH_SPACE);
      end
    end
    // end of script, either flavour
    if ($urandom_range(0, 3) == 0) send_req(1'b0, stk_pkg::CH_NUL);
    else send_req(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    while (tok_due.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) pop <= ($urandom_range(0, 99) >= stall_pct);

  function automatic void cmp_field(string fname, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : res_chk
    stk_pkg::res_t want;
    if (rst_ni && pop && !empty) begin
      res_seen++;
      if (tok_due.size() == 0) begin
        $display("%0t: unexpected token item: expected none, actual %p", $time, res_o);
        mismatches++;
      end else begin
        want = tok_due.pop_front();
        cmp_field("token_class", want.token_class, res_o.token_class);
        cmp_field("tok_char",    want.tok_char,    res_o.tok_char);
        cmp_field("char_valid",  want.char_valid,  res_o.char_valid);
        cmp_field("last",        want.last,        res_o.last);
        cmp_field("row_num",     want.row_num,     res_o.row_num);
        cmp_field("col_num",     want.col_num,     res_o.col_num);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run
    int goal;
    lex_clear();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows, no idling
    foreach (dir_tab[i])
      send_req(dir_tab[i].req.req_type, dir_tab[i].req.ch, dir_tab[i].typed,
               dir_tab[i].want);

    // random scripts over the four flow-control phases
    fed = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = send_idle[ph];
      stall_pct = recv_stall[ph];
      goal = fed + 90;
      while (fed < goal) feed_script($urandom_range(0, 6) == 0);
      // hold off until the block has caught up
      push <= 1'b0;
      wait_drained();
    end

    stall_pct = 0;
    repeat (8) @(posedge clk_i);
    $display("Covered %0d random requests over four flow-control phases after a",
             fed);
    $display("directed table; %0d token items checked.", res_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("Timed out with %0d token items outstanding", tok_due.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/stk_pkg.sv
sv/stk_front.sv
sv/stk_queue.sv
sv/stk_back.sv
sv/script_tokenizer.sv
sv/stk_checker.sv
verif/tb.sv
